// File: hw/rtl/life_pkg.sv
// Shared sizes, codes and payload types of the life automaton block.
package life_pkg;

    // Grid capacity
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Column and row address widths
    localparam int COL_AW  = $clog2(MAX_WIDTH);
    localparam int ROW_AW  = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // Width that holds any size value and any 7-bit size register
    localparam int DIM_W   = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;

    // Configuration port
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = 7'd64;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // Operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    typedef logic [MAX_WIDTH-1:0] row_t;
    typedef logic [DIM_W-1:0]     dim_t;

    // Request payload
    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] col_index;
        logic [5:0] row_index;
        logic       write_value;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic read_value;
        logic stable_flag;
        logic empty_flag;
    } out_item_t;

    // Row memory access
    typedef struct packed {
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        row_t              wr_data;
    } mem_req_t;

    // Per-row status of one generation step
    typedef struct packed {
        logic changed;
        logic alive;
    } row_flags_t;

endpackage

// File: hw/rtl/life_row_mem.sv
// Cell row memory: one row per entry, registered read, per-row valid bits.
module life_row_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  life_pkg::mem_req_t req,
    output life_pkg::row_t     rd_row
);
    import life_pkg::*;

    row_t                  rows_mem [MAX_HEIGHT];
    row_t                  rd_data_reg;
    logic                  rd_valid_reg;
    logic [MAX_HEIGHT-1:0] valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            rows_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= rows_mem[req.rd_addr];
        end
    end

    // Rows never written read as all dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/life_row_update.sv
// Next-generation logic for one row, B3/S23 with column wraparound.
module life_row_update (
    input  life_pkg::row_t       prev_row,
    input  life_pkg::row_t       cur_row,
    input  life_pkg::row_t       next_row,
    input  life_pkg::dim_t       width,
    output life_pkg::row_t       new_row,
    output life_pkg::row_flags_t flags
);
    import life_pkg::*;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    dim_t              last_dim;
    logic [COL_AW-1:0] last_col;
    logic              prev_last;
    logic              cur_last;
    logic              next_last;

    // Rightmost active column feeds the left neighbor of column zero
    assign last_dim  = width - dim_t'(1);
    assign last_col  = last_dim[COL_AW-1:0];
    assign prev_last = prev_row[last_col];
    assign cur_last  = cur_row[last_col];
    assign next_last = next_row[last_col];

    // One lane per column
    always_comb
    begin
        logic       pl, pr, cl, cr, nl, nr;
        logic       nb, active;
        logic [3:0] n;
        new_row       = cur_row;
        flags.changed = 1'b0;
        flags.alive   = 1'b0;
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            if (c == 0)
            begin
                pl = prev_last;
                cl = cur_last;
                nl = next_last;
            end
            else
            begin
                pl = prev_row[(c + MAX_WIDTH - 1) % MAX_WIDTH];
                cl = cur_row[(c + MAX_WIDTH - 1) % MAX_WIDTH];
                nl = next_row[(c + MAX_WIDTH - 1) % MAX_WIDTH];
            end
            if (c == MAX_WIDTH - 1 || COL_AW'(c) == last_col)
            begin
                pr = prev_row[0];
                cr = cur_row[0];
                nr = next_row[0];
            end
            else
            begin
                pr = prev_row[(c + 1) % MAX_WIDTH];
                cr = cur_row[(c + 1) % MAX_WIDTH];
                nr = next_row[(c + 1) % MAX_WIDTH];
            end
            n = 4'(pl) + 4'(prev_row[c]) + 4'(pr) + 4'(cl) + 4'(cr)
              + 4'(nl) + 4'(next_row[c]) + 4'(nr);
            if (cur_row[c])
            begin
                nb = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
            end
            else
            begin
                nb = (n == BIRTH_COUNT);
            end
            active = (dim_t'(c) < width);
            if (active)
            begin
                new_row[c] = nb;
                if (nb != cur_row[c])
                begin
                    flags.changed = 1'b1;
                end
                if (nb)
                begin
                    flags.alive = 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/life_automaton_step.sv
// Top level: toroidal B3/S23 cell grid with write, read and advance requests.
//
// Usage:
//   in_valid/in_ready/in_item carry one request: write a cell, read a cell or
//   advance one generation. Every request returns one result on
//   out_valid/out_ready/out_item (read_value, stable_flag, empty_flag).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write grid_width (index 0) and
//   grid_height (index 1); cfg_ready is always high. Write sizes only while
//   no request is in flight.
// Timing:
//   A read or write inside the active region passes through S_CELL (row modify
//   and write-back, or read value capture) and S_HOLD (result load) before
//   out_valid rises; outside the region, and for the unused code, it goes
//   straight to S_HOLD. An advance sweeps the grid one row per cycle in S_SWEEP
//   through the single row memory port pair, keeping a three-row window plus a
//   copy of row zero, then writes the last row in S_LAST. One request is in
//   progress at a time; in_ready is high only when idle and rises with out_valid.
// Reset:
//   Sizes return to 64 by 64 and every cell reads dead; rows become valid as
//   they are written, so no clearing pass is needed.
// Stall:
//   A finished result waits in an internal register until the output register
//   is free; no new request is taken until it has moved out.
module life_automaton_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  life_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output life_pkg::out_item_t                 out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [life_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [life_pkg::SIZE_W-1:0]         cfg_data
);
    import life_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_SWEEP,
        S_LAST,
        S_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] width_reg, height_reg;
    dim_t              w_eff, h_eff;
    dim_t              col_ext, row_ext;
    logic              in_range;
    logic [1:0]        op_reg, op_next;
    logic [COL_AW-1:0] col_reg, col_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic              val_reg, val_next;
    dim_t              k_reg, k_next;
    dim_t              k_m2, h_m1;
    row_t              prev_reg, prev_next;
    row_t              cur_reg, cur_next;
    row_t              row0_reg, row0_next;
    logic              stable_reg, stable_next;
    logic              empty_reg, empty_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    mem_req_t          mem_req;
    row_t              mem_row;
    row_t              cell_row;
    row_t              upd_next_row;
    row_t              upd_row;
    row_flags_t        upd_flags;

    // Size registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = dim_t'(1);
        else if (dim_t'(width_reg) > dim_t'(MAX_WIDTH))
            w_eff = dim_t'(MAX_WIDTH);
        else
            w_eff = dim_t'(width_reg);
        if (height_reg == '0)
            h_eff = dim_t'(1);
        else if (dim_t'(height_reg) > dim_t'(MAX_HEIGHT))
            h_eff = dim_t'(MAX_HEIGHT);
        else
            h_eff = dim_t'(height_reg);
    end

    assign col_ext  = dim_t'(in_item.col_index);
    assign row_ext  = dim_t'(in_item.row_index);
    assign in_range = (col_ext < w_eff) && (row_ext < h_eff);
    assign k_m2     = k_reg - dim_t'(2);
    assign h_m1     = h_eff - dim_t'(1);

    // Row memory and row update unit
    life_row_mem u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (mem_row)
    );

    assign upd_next_row = (state_reg == S_LAST) ? row0_reg : mem_row;

    life_row_update u_update (
        .prev_row (prev_reg),
        .cur_row  (cur_reg),
        .next_row (upd_next_row),
        .width    (w_eff),
        .new_row  (upd_row),
        .flags    (upd_flags)
    );

    // Single-cell modify for writes
    always_comb
    begin
        cell_row          = mem_row;
        cell_row[col_reg] = val_reg;
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        val_next       = val_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        row0_next      = row0_reg;
        stable_next    = stable_reg;
        empty_next     = empty_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mem_req        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_item.operation;
                    col_next = col_ext[COL_AW-1:0];
                    row_next = row_ext[ROW_AW-1:0];
                    val_next = in_item.write_value;
                    res_next = '0;
                    case (in_item.operation)
                        OP_WRITE, OP_READ:
                        begin
                            if (in_range)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = row_ext[ROW_AW-1:0];
                                state_next      = S_CELL;
                            end
                            else
                            begin
                                state_next = S_HOLD;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            // Last row first, it is the upper neighbor of row zero
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = h_m1[ROW_AW-1:0];
                            k_next          = '0;
                            stable_next     = 1'b1;
                            empty_next      = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_HOLD;
                        end
                    endcase
                end
            end

            S_CELL:
            begin
                if (op_reg == OP_WRITE)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = row_reg;
                    mem_req.wr_data = cell_row;
                end
                else
                begin
                    res_next.read_value = mem_row[col_reg];
                end
                state_next = S_HOLD;
            end

            S_SWEEP:
            begin
                // Row k-1 of the old grid arrives now for k above zero
                if (k_reg < h_eff)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = k_reg[ROW_AW-1:0];
                end
                if (k_reg == '0)
                begin
                    prev_next = mem_row;
                end
                else if (k_reg == dim_t'(1))
                begin
                    cur_next  = mem_row;
                    row0_next = mem_row;
                end
                else
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = k_m2[ROW_AW-1:0];
                    mem_req.wr_data = upd_row;
                    prev_next       = cur_reg;
                    cur_next        = mem_row;
                    stable_next     = stable_reg & ~upd_flags.changed;
                    empty_next      = empty_reg & ~upd_flags.alive;
                end
                if (k_reg == h_eff)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    k_next = k_reg + dim_t'(1);
                end
            end

            S_LAST:
            begin
                // Last row wraps to the saved old row zero
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = h_m1[ROW_AW-1:0];
                mem_req.wr_data      = upd_row;
                res_next.read_value  = 1'b0;
                res_next.stable_flag = stable_reg & ~upd_flags.changed;
                res_next.empty_flag  = empty_reg & ~upd_flags.alive;
                state_next           = S_HOLD;
            end

            S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            val_reg       <= 1'b0;
            k_reg         <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            row0_reg      <= '0;
            stable_reg    <= 1'b0;
            empty_reg     <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            val_reg       <= val_next;
            k_reg         <= k_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            row0_reg      <= row0_next;
            stable_reg    <= stable_next;
            empty_reg     <= empty_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg != S_IDLE))
        else $error("row memory written while idle");

    a_no_same_row_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("row read and written in the same cycle");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (k_reg <= h_eff))
        else $error("sweep row count past grid height");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

// File: dv/life_automaton_step_test.sv
// Self-checking testbench for life_automaton_step: requests checked against a grid predictor.
module life_automaton_step_test;
    import life_pkg::*;

    // Operation code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 40;

    typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Predicted grid, size registers and queue of expected results
    class life_grid_board;
        row_t              cells [MAX_HEIGHT];
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        out_item_t         expected_results [$];
        int unsigned       mismatches;

        function new();
            foreach (cells[r])
                cells[r] = '0;
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // 0 acts as 1, anything past the capacity acts as the capacity
        function int unsigned clamp_size(logic [SIZE_W-1:0] value, int unsigned limit);
            if (value == 0)
                return 1;
            if (value > limit)
                return limit;
            return value;
        endfunction

        function int unsigned active_cols();
            return clamp_size(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned active_rows();
            return clamp_size(height_reg, MAX_HEIGHT);
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
            if (index == REG_GRID_WIDTH)
                width_reg = value;
            else if (index == REG_GRID_HEIGHT)
                height_reg = value;
        endfunction

        // One B3/S23 generation over the active region, wrapping on both axes
        function void advance_generation(int unsigned cols, int unsigned rows,
                                         output logic stable, output logic empty);
            row_t        prior [MAX_HEIGHT];
            int unsigned r, c, dr, dc, nr, nc, count;
            logic        next;
            prior  = cells;
            stable = 1'b1;
            empty  = 1'b1;
            for (r = 0; r < rows; r++)
            begin
                for (c = 0; c < cols; c++)
                begin
                    count = 0;
                    // tiny grids may count a cell or a neighbor more than once
                    for (dr = 0; dr < 3; dr++)
                    begin
                        for (dc = 0; dc < 3; dc++)
                        begin
                            if (dr != 1 || dc != 1)
                            begin
                                nr = (r + rows + dr - 1) % rows;
                                nc = (c + cols + dc - 1) % cols;
                                count += prior[nr][nc];
                            end
                        end
                    end
                    next = prior[r][c] ? (count == 2 || count == 3) : (count == 3);
                    cells[r][c] = next;
                    if (next != prior[r][c])
                        stable = 1'b0;
                    if (next)
                        empty = 1'b0;
                end
            end
        endfunction

        function void note_request(in_item_t req);
            out_item_t   result;
            int unsigned cols, rows;
            logic        stable, empty;
            bit          in_region;
            cols      = active_cols();
            rows      = active_rows();
            in_region = (req.col_index < cols) && (req.row_index < rows);
            result    = '0;
            case (req.operation)
                OP_WRITE:
                    if (in_region)
                        cells[req.row_index][req.col_index] = req.write_value;
                OP_READ:
                    if (in_region)
                        result.read_value = cells[req.row_index][req.col_index];
                OP_ADVANCE:
                begin
                    advance_generation(cols, rows, stable, empty);
                    result.stable_flag = stable;
                    result.empty_flag  = empty;
                end
                default: ;
            endcase
            expected_results.push_back(result);
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %b with nothing expected", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value %b, want %b",
                                          got.read_value, want.read_value));
            if (got.stable_flag !== want.stable_flag)
                report_mismatch($sformatf("stable_flag %b, want %b",
                                          got.stable_flag, want.stable_flag));
            if (got.empty_flag !== want.empty_flag)
                report_mismatch($sformatf("empty_flag %b, want %b",
                                          got.empty_flag, want.empty_flag));
        endtask

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    life_grid_board board = new();
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    hold_left = 0;

    life_automaton_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: check accepted results, then pick out_ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(out_item);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_item_t make_request(logic [1:0] op, int unsigned col,
                                              int unsigned row, logic value);
        in_item_t req;
        req.operation   = op;
        req.col_index   = 6'(col);
        req.row_index   = 6'(row);
        req.write_value = value;
        return req;
    endfunction

    // Mostly in-region cells, sometimes any index so every address bit toggles
    function automatic in_item_t random_request(bit seeding);
        in_item_t    req;
        int unsigned roll, cols, rows;
        cols = board.active_cols();
        rows = board.active_rows();
        roll = $urandom_range(99);
        if (seeding || roll < 44)
            req.operation = OP_WRITE;
        else if (roll < 72)
            req.operation = OP_READ;
        else if (roll < 95)
            req.operation = OP_ADVANCE;
        else
            req.operation = OP_UNUSED;
        req.col_index = ($urandom_range(99) < 85) ? 6'($urandom_range(cols - 1))
                                                  : 6'($urandom_range(63));
        req.row_index = ($urandom_range(99) < 85) ? 6'($urandom_range(rows - 1))
                                                  : 6'($urandom_range(63));
        req.write_value = seeding ? 1'b1 : 1'($urandom_range(1));
        return req;
    endfunction

    // Offer one request, with random gaps before it; returns on acceptance
    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(req);
    endtask

    task automatic set_grid_size(input logic [SIZE_W-1:0] width_val,
                                 input logic [SIZE_W-1:0] height_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= width_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_size(REG_GRID_WIDTH, width_val);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= height_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_size(REG_GRID_HEIGHT, height_val);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait for every expected result; ends on a falling edge
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] width_val,
                             input logic [SIZE_W-1:0] height_val,
                             input int unsigned count, input idle_mode_t mode,
                             input bit hold);
        int unsigned k, seeds;
        settle();
        send_idle_pct  = (mode == IDLE_SENDER) ? 67 : (mode == IDLE_BOTH) ? 36 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 67 : (mode == IDLE_BOTH) ? 36 : 0;
        if (hold)
            hold_left = HOLD_CYCLES;
        @(posedge clk);
        set_grid_size(width_val, height_val);
        // seed a soup of live cells, then mixed traffic
        seeds = board.active_cols() * board.active_rows() / 3 + 1;
        if (seeds > count / 3)
            seeds = count / 3;
        for (k = 0; k < count; k++)
            send_request(random_request(k < seeds));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, a still life wrapped over both edges, a blinker
        send_request(make_request(OP_WRITE, 0, 0, 1'b1));
        send_request(make_request(OP_READ, 0, 0, 1'b0));
        send_request(make_request(OP_READ, 5, 5, 1'b0));
        send_request(make_request(OP_WRITE, 63, 63, 1'b1));
        send_request(make_request(OP_WRITE, 63, 0, 1'b1));
        send_request(make_request(OP_WRITE, 0, 63, 1'b1));
        send_request(make_request(OP_READ, 63, 63, 1'b0));
        send_request(make_request(OP_ADVANCE, 0, 0, 1'b0));
        send_request(make_request(OP_WRITE, 0, 0, 1'b0));
        send_request(make_request(OP_ADVANCE, 63, 63, 1'b1));
        send_request(make_request(OP_ADVANCE, 0, 0, 1'b0));
        send_request(make_request(OP_READ, 0, 0, 1'b0));
        send_request(make_request(OP_WRITE, 0, 0, 1'b0));
        send_request(make_request(OP_WRITE, 63, 63, 1'b0));
        send_request(make_request(OP_WRITE, 63, 0, 1'b0));
        send_request(make_request(OP_WRITE, 0, 63, 1'b0));
        send_request(make_request(OP_ADVANCE, 0, 0, 1'b0));
        send_request(make_request(OP_WRITE, 10, 9, 1'b1));
        send_request(make_request(OP_WRITE, 10, 10, 1'b1));
        send_request(make_request(OP_WRITE, 10, 11, 1'b1));
        send_request(make_request(OP_ADVANCE, 0, 0, 1'b0));
        send_request(make_request(OP_ADVANCE, 0, 0, 1'b0));
        send_request(make_request(OP_UNUSED, 63, 63, 1'b1));
        send_request(make_request(OP_READ, 10, 10, 1'b1));

        // Random phases over sizes, out-of-range size values included
        run_phase(7'd8,   7'd8,   120, IDLE_NONE,     1'b0);
        run_phase(7'd1,   7'd1,   60,  IDLE_SENDER,   1'b0);
        run_phase(7'd2,   7'd2,   60,  IDLE_RECEIVER, 1'b1);
        run_phase(7'd0,   7'd0,   40,  IDLE_BOTH,     1'b0);
        run_phase(7'd127, 7'd100, 90,  IDLE_NONE,     1'b0);
        run_phase(7'd5,   7'd3,   120, IDLE_SENDER,   1'b0);
        run_phase(7'd1,   7'd64,  60,  IDLE_RECEIVER, 1'b0);
        run_phase(7'd64,  7'd1,   80,  IDLE_BOTH,     1'b1);
        run_phase(7'd2,   7'd7,   100, IDLE_NONE,     1'b0);
        run_phase(7'd16,  7'd12,  140, IDLE_SENDER,   1'b0);
        run_phase(7'd3,   7'd3,   100, IDLE_RECEIVER, 1'b0);
        run_phase(7'd64,  7'd64,  80,  IDLE_BOTH,     1'b0);
        run_phase(7'd40,  7'd33,  100, IDLE_NONE,     1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("PASS life_automaton_step");
        else
            $display("FAIL life_automaton_step");
        $finish;
    end

    // Run limit, several times the slowest correct run
    initial
    begin
        #6000000;
        $display("FAIL life_automaton_step");
        $finish;
    end

endmodule
